/* src/xcfr_pkg.sv */
// ============================================================================
// xcfr_pkg
// Shared types and constants for the XOR-checked frame receiver.
// ============================================================================
package xcfr_pkg;

    localparam int FRAME_LEN = 8;                      // bytes per frame, 3..64
    localparam int IDX_W     = $clog2(FRAME_LEN);      // frame store address
    localparam int WI_W      = $clog2(FRAME_LEN + 1);  // write index, 0..FRAME_LEN

    localparam int BYTE_W    = 8;
    localparam int TICK_W    = 16;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // input item codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    // configuration reset values
    localparam logic [BYTE_W-1:0] START_RST   = 8'h00;
    localparam logic [BYTE_W-1:0] END_RST     = 8'hFF;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;

    // checksum seed
    localparam logic [BYTE_W-1:0] XOR_SEED = 8'h00;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // frame store access from the controller
    typedef struct packed {
        logic  wr_en;
        idx_t  wr_addr;
        byte_t wr_data;
        logic  rd_en;
        idx_t  rd_addr;
    } store_req_t;

endpackage

/* src/xcfr_if.sv */
// ============================================================================
// xcfr_in_if / xcfr_out_if
// Valid/ready channels for received items and verified frame bytes.
// ============================================================================
interface xcfr_in_if;
    import xcfr_pkg::*;

    logic        valid;
    logic        ready;
    logic        cmd;
    byte_t       rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface xcfr_out_if;
    import xcfr_pkg::*;

    logic             valid;
    logic             ready;
    byte_t            frame_byte;
    logic [POS_W-1:0] byte_position;
    logic             last_of_frame;

    modport source (output valid, output frame_byte, output byte_position,
                    output last_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input last_of_frame, output ready);
endinterface

/* src/xcfr_ram.sv */
// ============================================================================
// xcfr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module xcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/xcfr_store.sv */
// ============================================================================
// xcfr_store
// Frame store: RAM plus per-entry valid bits; unwritten entries read as zero.
// ============================================================================
module xcfr_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  xcfr_pkg::store_req_t   req,
    output xcfr_pkg::byte_t        rd_data
);
    import xcfr_pkg::*;

    logic [FRAME_LEN-1:0] vld_reg;
    logic                 rd_vld_reg;
    byte_t                ram_q;

    xcfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_LEN)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? ram_q : '0;

endmodule

/* src/xor_checked_frame_receiver_unit.sv */
// ============================================================================
// xor_checked_frame_receiver_unit
// Start/end delimited frame receiver with XOR checksum over a frame store.
// ============================================================================
//
//  channel   dir   handshake        payload
//  -------   ---   --------------   ---------------------------------------
//  in_ch     in    valid/ready      cmd, rx_byte
//  out_ch    out   valid/ready      frame_byte, byte_position, last_of_frame
//  cfg       in    cfg_we (no ack)  cfg_index, cfg_data
//
//  A tick, or a byte that does not trigger a verify, is handled in ST_IDLE.
//  A verifying byte starts a checksum walk through the store's single read
//  port, then each emitted byte is read, then shown until out_ch takes it;
//  in_ch is held off meanwhile.
//  Reset is immediate: store entries carry valid bits and read as zero until
//  written, so there is no clearing pass.
//
module xor_checked_frame_receiver_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    xcfr_in_if.sink                           in_ch,
    xcfr_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [xcfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [xcfr_pkg::CFG_W-1:0]        cfg_data
);
    import xcfr_pkg::*;

    localparam idx_t          LAST_IDX = idx_t'(FRAME_LEN - 1);
    localparam idx_t          SUM_IDX  = idx_t'(FRAME_LEN - 2);
    localparam logic [WI_W-1:0] WI_END = WI_W'(FRAME_LEN);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,       // stream reads 0..FRAME_LEN-2, fold XOR
        ST_CHECK_END,   // checksum byte arrives, compare
        ST_EMIT_LOAD,   // read frame byte at idx
        ST_EMIT_SHOW    // present it until taken
    } state_t;

    state_t            state_reg, state_next;
    idx_t              idx_reg, idx_next;       // walk position, check and emit
    byte_t             acc_reg, acc_next;       // running XOR
    logic              in_frame_reg, in_frame_next;
    logic [WI_W-1:0]   wi_reg, wi_next;
    logic              vp_reg, vp_next;         // verify armed
    logic [TICK_W-1:0] ticks_reg, ticks_next;

    byte_t             start_reg, end_reg;
    logic [TICK_W-1:0] timeout_reg;

    store_req_t        req;
    byte_t             rd_data;

    logic              in_fire;
    logic              is_start, is_end;
    logic [WI_W-1:0]   wi_eff;
    logic [TICK_W-1:0] ticks_inc;

    xcfr_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= START_RST;
            end_reg     <= END_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START:   start_reg   <= cfg_data[BYTE_W-1:0];
                REG_END:     end_reg     <= cfg_data[BYTE_W-1:0];
                REG_TIMEOUT: timeout_reg <= cfg_data[TICK_W-1:0];
                default:     ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    // start wins over end when both match
    assign is_start  = (in_ch.rx_byte == start_reg);
    assign is_end    = !is_start && (in_ch.rx_byte == end_reg) && in_frame_reg;
    assign wi_eff    = is_start ? '0 : wi_reg;
    assign ticks_inc = (ticks_reg != '1) ? ticks_reg + TICK_W'(1) : ticks_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        in_frame_next = in_frame_reg;
        wi_next       = wi_reg;
        vp_next       = vp_reg;
        ticks_next    = ticks_reg;

        req.wr_en   = 1'b0;
        req.wr_addr = wi_eff[IDX_W-1:0];
        req.wr_data = in_ch.rx_byte;
        req.rd_en   = 1'b0;
        req.rd_addr = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.cmd == CMD_TICK)
                    begin
                        ticks_next = ticks_inc;
                        // frame timed out: drop it, verify on next byte
                        if (in_frame_reg && (ticks_inc > timeout_reg))
                        begin
                            in_frame_next = 1'b0;
                            wi_next       = '0;
                            vp_next       = 1'b1;
                        end
                    end
                    else
                    begin
                        // at most one store per byte; writes past the buffer are dropped
                        req.wr_en = (is_start || in_frame_reg) && (wi_eff < WI_END);
                        if (is_start)
                        begin
                            in_frame_next = 1'b1;
                            wi_next       = WI_W'(1);
                            ticks_next    = '0;
                        end
                        else if (is_end)
                        begin
                            in_frame_next = 1'b0;   // end byte keeps the index
                        end
                        else if (in_frame_reg && (wi_reg < WI_END))
                        begin
                            wi_next = wi_reg + WI_W'(1);
                        end
                        if (vp_reg || is_end)
                        begin
                            vp_next    = 1'b0;
                            idx_next   = '0;
                            acc_next   = XOR_SEED;
                            state_next = ST_CHECK;
                        end
                    end
                end
            end

            ST_CHECK:
            begin
                req.rd_en = 1'b1;
                // data of idx-1 arrives this cycle
                if (idx_reg != '0)
                begin
                    acc_next = acc_reg ^ rd_data;
                end
                if (idx_reg == SUM_IDX)
                begin
                    state_next = ST_CHECK_END;
                end
                else
                begin
                    idx_next = idx_reg + idx_t'(1);
                end
            end

            ST_CHECK_END:
            begin
                idx_next   = '0;
                state_next = (acc_reg == rd_data) ? ST_EMIT_LOAD : ST_IDLE;
            end

            ST_EMIT_LOAD:
            begin
                req.rd_en  = 1'b1;
                state_next = ST_EMIT_SHOW;
            end

            ST_EMIT_SHOW:
            begin
                if (out_ch.ready)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + idx_t'(1);
                        state_next = ST_EMIT_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            acc_reg      <= XOR_SEED;
            in_frame_reg <= 1'b0;
            wi_reg       <= '0;
            vp_reg       <= 1'b0;
            ticks_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            acc_reg      <= acc_next;
            in_frame_reg <= in_frame_next;
            wi_reg       <= wi_next;
            vp_reg       <= vp_next;
            ticks_reg    <= ticks_next;
        end
    end

    // store read data holds while shown, so the payload is stable on stall
    assign out_ch.valid         = (state_reg == ST_EMIT_SHOW);
    assign out_ch.frame_byte    = rd_data;
    assign out_ch.byte_position = POS_W'(idx_reg);
    assign out_ch.last_of_frame = (idx_reg == LAST_IDX);

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken while a frame is being emitted");

    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last_of_frame) |=> in_ch.ready)
        else $error("not ready after last byte of frame");

    a_wi_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wi_reg <= WI_END)
        else $error("write index beyond frame length");

    a_verify_closed: assert property (@(posedge clk) disable iff (!rst_n)
        vp_reg |-> !in_frame_reg)
        else $error("verify armed while a frame is open");

endmodule

/* tb/tb.sv */
// ============================================================================
// tb: XOR-checked frame receiver testbench
// Drives received bytes and ticks into the receiver, mirrors its frame store,
// open/close and timeout behavior in a shadow predictor, and checks every
// emitted frame byte in order against the predicted ones.
// ============================================================================
module tb;
    import xcfr_pkg::*;

    // register index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int DRAIN_CYCLES     = 40;        // verify walk + last emit, with margin
    localparam int SINK_HOLD_CYCLES = 300;       // long output back-pressure
    localparam int MAX_REPORTS      = 10;
    localparam int WATCHDOG         = 16000000;  // simulation time limit
    localparam int RAND_PHASES      = 4;
    localparam int PHASE_ITEMS      = 18;        // items per random phase, at least

    // one predicted output item
    typedef struct packed {
        byte_t            data;
        logic [POS_W-1:0] pos;
        logic             last;
    } frame_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    xcfr_in_if  in_if ();
    xcfr_out_if out_if ();

    xor_checked_frame_receiver_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the receiver: configuration and frame state
    // ------------------------------------------------------------------
    byte_t             cur_sof   = START_RST;
    byte_t             cur_eof   = END_RST;
    logic [TICK_W-1:0] cur_limit = TIMEOUT_RST;

    byte_t             shadow_buf [FRAME_LEN];
    logic              shadow_open;
    int                shadow_wptr;       // 0..FRAME_LEN, saturating
    logic              shadow_check_due;  // verify armed
    logic [TICK_W-1:0] shadow_age;        // ticks since last start byte

    frame_beat_t pending_beats [$];       // predicted, not yet emitted

    int errors;
    int hold_left;    // long output hold, counted down by the ready driver
    int stall_left;   // short per-item output stall
    bit in_idle_on;
    bit out_idle_on;

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(WATCHDOG);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // XOR of every stored byte ahead of the checksum slot vs. the checksum slot
    function automatic logic frame_sum_ok();
        byte_t acc;
        acc = XOR_SEED;
        for (int i = 0; i < FRAME_LEN - 2; i++)
            acc ^= shadow_buf[i];
        return acc == shadow_buf[FRAME_LEN-2];
    endfunction

    // apply one accepted item to the shadow and queue any frame bytes it releases
    function automatic void advance_receiver(input logic c, input byte_t b);
        frame_beat_t beat;
        if (c == CMD_TICK)
        begin
            if (shadow_age != '1)
                shadow_age++;
            // stale frame: drop it, but the next byte still runs a verify
            if (shadow_open && shadow_age > cur_limit)
            begin
                shadow_open      = 1'b0;
                shadow_wptr      = 0;
                shadow_check_due = 1'b1;
            end
            return;
        end

        // start wins when start and end bytes are the same value
        if (b == cur_sof)
        begin
            shadow_open = 1'b1;
            shadow_wptr = 0;
            shadow_age  = '0;
        end
        else if (b == cur_eof && shadow_open)
        begin
            // end byte lands at the current slot, index does not move
            shadow_open = 1'b0;
            if (shadow_wptr < FRAME_LEN)
                shadow_buf[shadow_wptr] = b;
            shadow_check_due = 1'b1;
        end

        // writes past the store are dropped, index sticks at FRAME_LEN
        if (shadow_open && shadow_wptr < FRAME_LEN)
        begin
            shadow_buf[shadow_wptr] = b;
            shadow_wptr++;
        end

        // verify runs after the byte is handled, on whatever the store holds
        if (shadow_check_due)
        begin
            shadow_check_due = 1'b0;
            if (frame_sum_ok())
            begin
                for (int i = 0; i < FRAME_LEN; i++)
                begin
                    beat.data = shadow_buf[i];
                    beat.pos  = POS_W'(i);
                    beat.last = (i == FRAME_LEN - 1);
                    pending_beats.push_back(beat);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: one item, with a random gap (when input idling is on) ahead of it
    // ------------------------------------------------------------------
    // Drives at the falling edge; valid is left high after acceptance so a
    // back-to-back item needs no drop. quiesce() lowers it.
    task automatic send_item(input logic c, input byte_t b);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.cmd     <= c;
        in_if.rx_byte <= b;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        advance_receiver(c, b);
    endtask

    // wait until all predicted bytes are out, then let a silent verify finish
    task automatic quiesce();
        @(negedge clk);
        in_if.valid <= 1'b0;
        wait (pending_beats.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port (only used with the block idle)
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_START:   cur_sof   = val[BYTE_W-1:0];
            REG_END:     cur_eof   = val[BYTE_W-1:0];
            REG_TIMEOUT: cur_limit = val[TICK_W-1:0];
            default:     ;
        endcase
    endtask

    // upper bits of the byte registers get junk to check the truncation
    task automatic set_config(input byte_t sof, input byte_t eof, input logic [TICK_W-1:0] lim);
        quiesce();
        write_reg(REG_START, {byte_t'($urandom), sof});
        write_reg(REG_END, {byte_t'($urandom), eof});
        write_reg(REG_TIMEOUT, lim);
    endtask

    // ------------------------------------------------------------------
    // Frame builder: start, payload, checksum, end
    // ------------------------------------------------------------------
    // Payload avoids the delimiters so the frame is not cut short; corrupt
    // flips one bit of the checksum.
    task automatic send_frame(input bit corrupt);
        byte_t body [FRAME_LEN];
        byte_t acc;
        do
        begin
            body[0] = cur_sof;
            acc     = XOR_SEED ^ cur_sof;
            for (int i = 1; i < FRAME_LEN - 2; i++)
            begin
                do
                    body[i] = byte_t'($urandom);
                while (body[i] == cur_sof || body[i] == cur_eof);
                acc ^= body[i];
            end
        end
        while (acc == cur_sof || acc == cur_eof);
        body[FRAME_LEN-2] = corrupt ? acc ^ (8'h01 << $urandom_range(0, 7)) : acc;
        body[FRAME_LEN-1] = cur_eof;
        foreach (body[i])
            send_item(CMD_BYTE, body[i]);
    endtask

    // ------------------------------------------------------------------
    // Output side: ready driver and result checker
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        frame_beat_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (out_idle_on)
                stall_left = $urandom_range(0, 4);
            if (pending_beats.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected frame item: byte %02h pos %0d last %0b",
                             out_if.frame_byte, out_if.byte_position, out_if.last_of_frame);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_if.frame_byte !== want.data || out_if.byte_position !== want.pos
                    || out_if.last_of_frame !== want.last)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("item mismatch: exp %02h/%0d/%0b got %02h/%0d/%0b",
                                 want.data, want.pos, want.last, out_if.frame_byte,
                                 out_if.byte_position, out_if.last_of_frame);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset delimiters (start 00, end FF): stray bytes, then a fixed frame
    // with extreme payload values.
    task automatic test_basic_frame();
        byte_t seq [10];
        seq = '{8'h55, 8'hFF, 8'h00, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h2A, 8'h2A, 8'hFF};
        foreach (seq[i])
            send_item(CMD_BYTE, seq[i]);
    endtask

    // Too many bytes before the end byte: extra bytes and the end byte are
    // dropped, the store still verifies. Then a short frame, which is checked
    // against leftovers from the previous one and fails.
    task automatic test_overflow_and_short();
        byte_t seq [15];
        seq = '{8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h11, 8'h66, 8'h77, 8'h88,
                8'hFF, 8'h00, 8'h9C, 8'h3B, 8'hFF};
        foreach (seq[i])
            send_item(CMD_BYTE, seq[i]);
    endtask

    // Start and end share a value: the frame's end byte reopens it, so only
    // the timeout closes it. The next byte then verifies the old contents.
    task automatic test_start_is_end();
        set_config(8'h7E, 8'h7E, 16'd3);
        send_frame(1'b0);
        repeat (4) send_item(CMD_TICK, byte_t'($urandom));
        send_item(CMD_BYTE, 8'h10);
    endtask

    // Zero timeout: the first tick in an open frame drops it.
    task automatic test_timeout_zero();
        set_config(8'h00, 8'hFF, 16'd0);
        send_item(CMD_TICK, byte_t'($urandom));   // no frame open: no effect
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h42);
        send_item(CMD_TICK, byte_t'($urandom));
        send_item(CMD_BYTE, 8'h42);               // stray byte runs the armed verify
    endtask

    // Tick count equal to the limit keeps the frame open; one more tick
    // expires it.
    task automatic test_timeout_edge();
        set_config(8'h5A, 8'hA5, 16'd4);
        send_item(CMD_BYTE, 8'h5A);
        repeat (4) send_item(CMD_TICK, byte_t'($urandom));
        send_item(CMD_BYTE, 8'h33);               // frame still open
        send_item(CMD_TICK, byte_t'($urandom));
        send_item(CMD_BYTE, 8'h33);
    endtask

    // Output held off for a long stretch while frames keep coming, so the
    // receiver blocks its input; then the sender waits for a full drain.
    task automatic test_output_hold();
        quiesce();
        hold_left = SINK_HOLD_CYCLES;
        repeat (3) send_frame(1'b0);
        quiesce();
    endtask

    // Random phases, each with fresh delimiters and timeout; mostly
    // well-formed frames, plus bad checksums, broken frames, ticks and noise.
    task automatic test_random_traffic();
        int                sent;
        int                pick;
        int                n;
        byte_t             sof;
        byte_t             eof;
        logic [TICK_W-1:0] lim;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            sof = byte_t'($urandom);
            eof = ($urandom_range(0, 4) == 0) ? sof : byte_t'($urandom);
            if (ph == 0)
            begin
                sof = 8'hFF;
                eof = 8'h00;
            end
            case ($urandom_range(0, 3))
                0:       lim = '0;
                1:       lim = TICK_W'($urandom_range(1, 6));
                2:       lim = TICK_W'($urandom_range(7, 40));
                default: lim = '1;
            endcase
            set_config(sof, eof, lim);
            write_reg(REG_SPARE, CFG_W'($urandom));
            // one phase runs with no idling on either side
            in_idle_on  = (ph != 2);
            out_idle_on = (ph != 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    send_frame(1'b0);
                    sent += FRAME_LEN;
                end
                else if (pick < 65)
                begin
                    send_frame(1'b1);
                    sent += FRAME_LEN;
                end
                else if (pick < 77)
                begin
                    // start, random body of 0 to 10 bytes, end
                    n = $urandom_range(0, 10);
                    send_item(CMD_BYTE, cur_sof);
                    repeat (n) send_item(CMD_BYTE, byte_t'($urandom));
                    send_item(CMD_BYTE, cur_eof);
                    sent += n + 2;
                end
                else if (pick < 89)
                begin
                    n = $urandom_range(1, 5);
                    repeat (n) send_item(CMD_TICK, byte_t'($urandom));
                    sent += n;
                end
                else if (pick < 97)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_item(CMD_BYTE, byte_t'($urandom));
                    sent += n;
                end
                else
                    quiesce();
            end
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_if.valid   = 1'b0;
        in_if.cmd     = CMD_BYTE;
        in_if.rx_byte = '0;
        out_if.ready  = 1'b0;
        errors        = 0;
        hold_left     = 0;
        stall_left    = 0;
        in_idle_on    = 1'b1;
        out_idle_on   = 1'b1;
        foreach (shadow_buf[i])
            shadow_buf[i] = '0;
        shadow_open      = 1'b0;
        shadow_wptr      = 0;
        shadow_check_due = 1'b0;
        shadow_age       = '0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_basic_frame();
        test_overflow_and_short();
        test_start_is_end();
        test_timeout_zero();
        test_timeout_edge();
        test_output_hold();
        test_random_traffic();

        quiesce();
        if (errors == 0 && pending_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/xcfr_pkg.sv
src/xcfr_if.sv
src/xcfr_ram.sv
src/xcfr_store.sv
src/xor_checked_frame_receiver_unit.sv
tb/tb.sv
